@@ rtl/slr_pkg.sv @@
// Shared types, constants and helper functions for the sample log ring.
// Used by slr_ring_mem and sample_log_ring_core; no dependencies.
package slr_pkg;

    localparam int RING_DEPTH   = 256;
    localparam int PTR_W        = $clog2(RING_DEPTH);
    localparam int SOURCE_COUNT = 8;
    localparam int SOURCE_W     = 3;
    localparam int SEQ_SLOTS    = 2 ** SOURCE_W;
    localparam int BURST_MAX    = 16;
    localparam int CNT_W        = $clog2(BURST_MAX + 1);
    localparam int VALUE_SLOTS  = 4;

    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_TAKE    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [2:0] STAT_STORED    = 3'd0;
    localparam logic [2:0] STAT_DROPPED   = 3'd1;
    localparam logic [2:0] STAT_IGNORED   = 3'd2;
    localparam logic [2:0] STAT_RECORD    = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;
    localparam logic [2:0] STAT_RESTARTED = 3'd5;

    typedef struct packed {
        logic [1:0]          kind;
        logic [2:0]          source;
        logic signed [15:0]  in_v0;
        logic signed [15:0]  in_v1;
        logic signed [15:0]  in_v2;
        logic signed [15:0]  in_v3;
        logic [7:0]          value_count;
        logic [31:0]         stamp;
        logic [4:0]          max_take;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          status;
        logic                last;
        logic [31:0]         rec_stamp;
        logic [2:0]          rec_source;
        logic [7:0]          rec_seq;
        logic signed [15:0]  rec_v0;
        logic signed [15:0]  rec_v1;
        logic signed [15:0]  rec_v2;
        logic signed [15:0]  rec_v3;
        logic [7:0]          fill_level;
        logic [31:0]         drop_total;
    } out_item_t;

    // one ring entry
    typedef struct packed {
        logic [31:0]         stamp;
        logic [2:0]          source;
        logic [7:0]          seq;
        logic signed [15:0]  v0;
        logic signed [15:0]  v1;
        logic signed [15:0]  v2;
        logic signed [15:0]  v3;
    } rec_t;

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_held(input logic [PTR_W-1:0] wp,
                                                   input logic [PTR_W-1:0] rp);
        logic [PTR_W:0] d;
        d = {1'b0, wp} - {1'b0, rp};
        if (wp < rp)
            d = d + (PTR_W + 1)'(RING_DEPTH);
        return d[PTR_W-1:0];
    endfunction

    function automatic logic [7:0] fill_sat(input logic [PTR_W-1:0] h);
        logic [31:0] w;
        w = 32'(h);
        return (w > 32'd255) ? 8'd255 : w[7:0];
    endfunction

endpackage

@@ rtl/sample_log_ring_core.sv @@
// Sample log ring top level: push / take / restart handling around the
// record memory. Depends on slr_pkg and slr_ring_mem.
// Push, restart and empty take: a new item every cycle while the output is not stalled.
// Take burst of N records: one record per cycle while the output is not
// stalled, once the memory read pipeline is primed.
// Reset: ring empty, drop counter, sequence numbers and source mask zero.
module sample_log_ring_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  slr_pkg::in_item_t   in_payload,
    output logic                out_valid,
    input  logic                out_stall,
    output slr_pkg::out_item_t  out_payload,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TAKE = 1'b1;

    logic                       state_reg, state_next;
    logic [slr_pkg::PTR_W-1:0]  wp_reg, wp_next;
    logic [slr_pkg::PTR_W-1:0]  rp_reg, rp_next;
    logic [31:0]                drop_reg, drop_next;
    logic [slr_pkg::CNT_W-1:0]  left_reg, left_next;
    logic [7:0]                 mask_reg, mask_next;
    logic [7:0]                 seq_reg [slr_pkg::SEQ_SLOTS];
    logic                       seq_clr, seq_inc;

    logic                       out_valid_reg;
    slr_pkg::out_item_t         out_payload_reg;
    slr_pkg::out_item_t         res;
    logic                       load;
    logic                       out_free;
    logic                       in_take;

    logic                       mem_we;
    slr_pkg::rec_t              new_rec;
    slr_pkg::rec_t              mem_q;

    logic                       src_ok;
    logic [7:0]                 cur_seq;
    logic [slr_pkg::PTR_W-1:0]  wp_adv, rp_adv;
    logic [slr_pkg::CNT_W-1:0]  lim;
    logic                       fin;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = (state_reg == ST_IDLE);

    assign cur_seq = seq_reg[in_payload.source];
    assign src_ok  = (32'(in_payload.source) < slr_pkg::SOURCE_COUNT)
                     && mask_reg[in_payload.source];
    assign wp_adv  = slr_pkg::ptr_advance(wp_reg);
    assign rp_adv  = slr_pkg::ptr_advance(rp_reg);
    assign lim     = (32'(in_payload.max_take) > slr_pkg::BURST_MAX)
                     ? slr_pkg::CNT_W'(slr_pkg::BURST_MAX)
                     : slr_pkg::CNT_W'(in_payload.max_take);
    assign fin     = (left_reg == slr_pkg::CNT_W'(1)) || (rp_adv == wp_reg);

    always_comb
    begin
        new_rec.stamp  = in_payload.stamp;
        new_rec.source = in_payload.source;
        new_rec.seq    = cur_seq;
        new_rec.v0     = (in_payload.value_count > 8'd0) ? in_payload.in_v0 : '0;
        new_rec.v1     = (in_payload.value_count > 8'd1) ? in_payload.in_v1 : '0;
        new_rec.v2     = (in_payload.value_count > 8'd2) ? in_payload.in_v2 : '0;
        new_rec.v3     = (in_payload.value_count > 8'd3) ? in_payload.in_v3 : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        drop_next  = drop_reg;
        left_next  = left_reg;
        mask_next  = mask_reg;
        seq_clr    = 1'b0;
        seq_inc    = 1'b0;
        mem_we     = 1'b0;
        load       = 1'b0;
        res        = '0;

        if (cfg_valid && cfg_ready)
        begin
            mask_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    unique case (in_payload.kind)
                        slr_pkg::KIND_PUSH:
                        begin
                            load     = 1'b1;
                            res.last = 1'b1;
                            if (!src_ok)
                            begin
                                res.status     = slr_pkg::STAT_IGNORED;
                                res.fill_level = slr_pkg::fill_sat(
                                    slr_pkg::ring_held(wp_reg, rp_reg));
                                res.drop_total = drop_reg;
                            end
                            else
                            begin
                                seq_inc        = 1'b1;
                                res.rec_stamp  = new_rec.stamp;
                                res.rec_source = new_rec.source;
                                res.rec_seq    = new_rec.seq;
                                res.rec_v0     = new_rec.v0;
                                res.rec_v1     = new_rec.v1;
                                res.rec_v2     = new_rec.v2;
                                res.rec_v3     = new_rec.v3;
                                if (wp_adv == rp_reg)
                                begin
                                    drop_next      = drop_reg + 32'd1;
                                    res.status     = slr_pkg::STAT_DROPPED;
                                    res.fill_level = slr_pkg::fill_sat(
                                        slr_pkg::ring_held(wp_reg, rp_reg));
                                    res.drop_total = drop_reg + 32'd1;
                                end
                                else
                                begin
                                    mem_we         = 1'b1;
                                    wp_next        = wp_adv;
                                    res.status     = slr_pkg::STAT_STORED;
                                    res.fill_level = slr_pkg::fill_sat(
                                        slr_pkg::ring_held(wp_adv, rp_reg));
                                    res.drop_total = drop_reg;
                                end
                            end
                        end
                        slr_pkg::KIND_TAKE:
                        begin
                            if ((lim == '0) || (wp_reg == rp_reg))
                            begin
                                load           = 1'b1;
                                res.status     = slr_pkg::STAT_EMPTY;
                                res.last       = 1'b1;
                                res.fill_level = slr_pkg::fill_sat(
                                    slr_pkg::ring_held(wp_reg, rp_reg));
                                res.drop_total = drop_reg;
                            end
                            else
                            begin
                                left_next  = lim;
                                state_next = ST_TAKE;
                            end
                        end
                        slr_pkg::KIND_RESTART:
                        begin
                            wp_next    = '0;
                            rp_next    = '0;
                            drop_next  = '0;
                            seq_clr    = 1'b1;
                            load       = 1'b1;
                            res.status = slr_pkg::STAT_RESTARTED;
                            res.last   = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TAKE:
            begin
                // mem_q always holds the entry at rp_reg here
                if (out_free)
                begin
                    load           = 1'b1;
                    rp_next        = rp_adv;
                    left_next      = left_reg - slr_pkg::CNT_W'(1);
                    res.status     = slr_pkg::STAT_RECORD;
                    res.last       = fin;
                    res.rec_stamp  = mem_q.stamp;
                    res.rec_source = mem_q.source;
                    res.rec_seq    = mem_q.seq;
                    res.rec_v0     = mem_q.v0;
                    res.rec_v1     = mem_q.v1;
                    res.rec_v2     = mem_q.v2;
                    res.rec_v3     = mem_q.v3;
                    res.fill_level = slr_pkg::fill_sat(
                        slr_pkg::ring_held(wp_reg, rp_adv));
                    res.drop_total = drop_reg;
                    if (fin)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read ahead at the next read pointer so the registered read data holds the head entry
    slr_ring_mem u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (wp_reg),
        .wr_data (new_rec),
        .rd_addr (rp_next),
        .rd_data (mem_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            drop_reg      <= '0;
            left_reg      <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < slr_pkg::SEQ_SLOTS; i++)
            begin
                seq_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            drop_reg  <= drop_next;
            left_reg  <= left_next;
            mask_reg  <= mask_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (seq_clr)
            begin
                for (int i = 0; i < slr_pkg::SEQ_SLOTS; i++)
                begin
                    seq_reg[i] <= '0;
                end
            end
            else if (seq_inc)
            begin
                seq_reg[in_payload.source] <= cur_seq + 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_payload_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_payload = out_payload_reg;

endmodule

@@ rtl/slr_ring_mem.sv @@
// Record storage of the log ring: one write port, one read port,
// registered read data. Depends on slr_pkg.
module slr_ring_mem (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [slr_pkg::PTR_W-1:0] wr_addr,
    input  slr_pkg::rec_t            wr_data,
    input  logic [slr_pkg::PTR_W-1:0] rd_addr,
    output slr_pkg::rec_t            rd_data
);

    slr_pkg::rec_t mem [slr_pkg::RING_DEPTH];
    slr_pkg::rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ test/sample_log_ring_tb_pkg.sv @@
// Record mirror for the sample log ring testbench: a shadow copy of the ring
// that works out the expected results per accepted beat. Depends on slr_pkg.
`timescale 1ns / 100ps
package sample_log_ring_tb_pkg;
    import slr_pkg::*;

    // Kind code the block ignores: no result, no state change.
    localparam logic [1:0] KIND_NONE = 2'd3;

    class log_ring_mirror;
        rec_t             ring_mem [RING_DEPTH];
        int               wr_ptr;
        int               rd_ptr;
        logic [31:0]      drops;
        logic [7:0]       seq_no [SEQ_SLOTS];
        logic [7:0]       source_mask;
        out_item_t        expected_records [$];
        int               mismatches;

        function new();
            wr_ptr = 0;
            rd_ptr = 0;
            drops = '0;
            foreach (seq_no[i]) seq_no[i] = '0;
            source_mask = '0;
            mismatches = 0;
        endfunction

        function void set_mask(logic [7:0] m);
            source_mask = m;
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        // fill level is taken after the state update, as the block reports it
        function out_item_t make_result(logic [2:0] st, logic fin, rec_t r);
            out_item_t o;
            int h;
            h = (wr_ptr - rd_ptr + RING_DEPTH) % RING_DEPTH;
            o.status     = st;
            o.last       = fin;
            o.rec_stamp  = r.stamp;
            o.rec_source = r.source;
            o.rec_seq    = r.seq;
            o.rec_v0     = r.v0;
            o.rec_v1     = r.v1;
            o.rec_v2     = r.v2;
            o.rec_v3     = r.v3;
            o.fill_level = (h > 255) ? 8'd255 : 8'(h);
            o.drop_total = drops;
            return o;
        endfunction

        function void apply_item(in_item_t it);
            rec_t r;
            int   lim;
            int   n;
            int   p;
            int   nxt;
            r = '0;
            case (it.kind)
                KIND_PUSH:
                begin
                    if (int'(it.source) >= SOURCE_COUNT || !source_mask[it.source]) begin
                        expected_records.push_back(make_result(STAT_IGNORED, 1'b1, r));
                        return;
                    end
                    r.stamp  = it.stamp;
                    r.source = it.source;
                    r.seq    = seq_no[it.source];
                    r.v0     = (it.value_count > 0) ? it.in_v0 : '0;
                    r.v1     = (it.value_count > 1) ? it.in_v1 : '0;
                    r.v2     = (it.value_count > 2) ? it.in_v2 : '0;
                    r.v3     = (it.value_count > 3) ? it.in_v3 : '0;
                    // sequence advances even when the record is lost
                    seq_no[it.source] = seq_no[it.source] + 8'd1;
                    nxt = (wr_ptr + 1) % RING_DEPTH;
                    if (nxt == rd_ptr) begin
                        drops = drops + 32'd1;
                        expected_records.push_back(make_result(STAT_DROPPED, 1'b1, r));
                    end else begin
                        ring_mem[wr_ptr] = r;
                        wr_ptr = nxt;
                        expected_records.push_back(make_result(STAT_STORED, 1'b1, r));
                    end
                end
                KIND_TAKE:
                begin
                    lim = (int'(it.max_take) > BURST_MAX) ? BURST_MAX : int'(it.max_take);
                    n = 0;
                    while (n < lim && rd_ptr != wr_ptr) begin
                        p = rd_ptr;
                        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                        expected_records.push_back(make_result(STAT_RECORD,
                            (n + 1 == lim) || (rd_ptr == wr_ptr), ring_mem[p]));
                        n++;
                    end
                    if (n == 0)
                        expected_records.push_back(make_result(STAT_EMPTY, 1'b1, r));
                end
                KIND_RESTART:
                begin
                    wr_ptr = 0;
                    rd_ptr = 0;
                    drops = '0;
                    foreach (seq_no[i]) seq_no[i] = '0;
                    expected_records.push_back(make_result(STAT_RESTARTED, 1'b1, r));
                end
                default:
                    ;
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_record(out_item_t got);
            out_item_t want;
            if (expected_records.size() == 0) begin
                $error("result with nothing expected: status %0d stamp %0h",
                       got.status, got.rec_stamp);
                mismatches++;
                return;
            end
            want = expected_records.pop_front();
            check_field("status", want.status, got.status);
            check_field("last", want.last, got.last);
            check_field("rec_stamp", want.rec_stamp, got.rec_stamp);
            check_field("rec_source", want.rec_source, got.rec_source);
            check_field("rec_seq", want.rec_seq, got.rec_seq);
            check_field("rec_v0", $unsigned(want.rec_v0), $unsigned(got.rec_v0));
            check_field("rec_v1", $unsigned(want.rec_v1), $unsigned(got.rec_v1));
            check_field("rec_v2", $unsigned(want.rec_v2), $unsigned(got.rec_v2));
            check_field("rec_v3", $unsigned(want.rec_v3), $unsigned(got.rec_v3));
            check_field("fill_level", want.fill_level, got.fill_level);
            check_field("drop_total", want.drop_total, got.drop_total);
        endfunction

        function void flag_leftovers();
            if (expected_records.size() != 0) begin
                $error("%0d expected results never arrived", expected_records.size());
                mismatches++;
            end
        endfunction
    endclass

endpackage

@@ test/sample_log_ring_core_tb.sv @@
// Testbench for sample_log_ring_core: directed and random push / take /
// restart beats under varying idle and stall. Depends on slr_pkg and
// sample_log_ring_tb_pkg.
`timescale 1ns / 100ps
module sample_log_ring_core_tb;
    import slr_pkg::*;
    import sample_log_ring_tb_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_SLACK      = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 45;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_payload = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_payload;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int stuck_cycles = 0;

    log_ring_mirror ring_log;

    sample_log_ring_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_payload  (in_payload),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_payload (out_payload),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    // input beat noted before the output check so a same-edge result finds it
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                ring_log.apply_item(in_payload);
            if (out_valid && !out_stall)
                ring_log.match_record(out_payload);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic in_item_t rand_item(logic [1:0] k);
        in_item_t it;
        it.kind        = k;
        it.source      = 3'($urandom_range(7));
        it.in_v0       = 16'($urandom);
        it.in_v1       = 16'($urandom);
        it.in_v2       = 16'($urandom);
        it.in_v3       = 16'($urandom);
        it.value_count = 8'($urandom);
        it.stamp       = $urandom;
        it.max_take    = 5'($urandom);
        return it;
    endfunction

    function automatic in_item_t push_item(logic [2:0] src, logic [7:0] cnt, logic [31:0] st);
        in_item_t it;
        it = rand_item(KIND_PUSH);
        it.source      = src;
        it.value_count = cnt;
        it.stamp       = st;
        return it;
    endfunction

    function automatic in_item_t push_fixed(logic [2:0] src, logic [7:0] cnt,
                                            logic [31:0] st, logic [15:0] v);
        in_item_t it;
        it = push_item(src, cnt, st);
        it.in_v0 = v;
        it.in_v1 = v;
        it.in_v2 = v;
        it.in_v3 = v;
        return it;
    endfunction

    function automatic in_item_t take_item(logic [4:0] n);
        in_item_t it;
        it = rand_item(KIND_TAKE);
        it.max_take = n;
        return it;
    endfunction

    task automatic send(input in_item_t it);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_payload <= it;
        do @(posedge clk); while (in_stall);
    endtask

    // always at least one edge, so valid never gets two updates in one step
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (ring_log.pending() != 0);
    endtask

    // an ignored kind may still be in flight once the last result is in
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(input logic [7:0] m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ring_log.set_mask(m);
    endtask

    task automatic random_phase(input int idle, input int stall, input logic [7:0] m,
                                input bit pause_mid);
        int       done;
        int       pick;
        in_item_t it;
        settle();
        write_mask(m);
        sender_idle_pct    = idle;
        receiver_stall_pct = stall;
        done = 0;
        while (done < PHASE_ITEMS) begin
            if (pause_mid && done == PHASE_ITEMS / 2)
                drain_results();
            pick = $urandom_range(99);
            if (pick < 55) begin
                it = rand_item(KIND_PUSH);
                if ($urandom_range(3) != 0)
                    it.value_count = 8'($urandom_range(5));
                done++;
            end else if (pick < 88) begin
                it = rand_item(KIND_TAKE);
                if ($urandom_range(3) != 0)
                    it.max_take = 5'($urandom_range(1, 8));
                done++;
            end else if (pick < 94) begin
                it = rand_item(KIND_RESTART);
                done++;
            end else begin
                it = rand_item(KIND_NONE);
            end
            send(it);
        end
    endtask

    initial
    begin
        ring_log = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mask cleared: every push is turned away
        write_mask(8'h00);
        send(push_item(3'd3, 8'd4, 32'h1111_0000));
        send(take_item(5'd4));
        send(rand_item(KIND_NONE));
        send(rand_item(KIND_RESTART));

        settle();
        write_mask(8'hFF);
        send(push_fixed(3'd0, 8'd0, 32'h0000_0000, 16'h7FFF));
        send(push_fixed(3'd7, 8'd255, 32'hFFFF_FFFF, 16'h8000));
        send(push_fixed(3'd2, 8'd1, 32'h0000_1234, 16'h7FFF));
        send(push_item(3'd5, 8'd3, 32'hA5A5_5A5A));
        send(push_item(3'd0, 8'd4, 32'h0000_0001));
        send(push_item(3'd0, 8'd5, 32'h8000_0000));
        send(take_item(5'd0));
        send(take_item(5'd2));
        send(take_item(5'd31));
        send(take_item(5'd1));
        send(push_item(3'd1, 8'd2, 32'h0000_00FF));
        send(rand_item(KIND_RESTART));
        send(push_item(3'd1, 8'd4, 32'h0001_0000));
        send(take_item(5'd16));

        settle();
        write_mask(8'h5A);
        send(push_item(3'd0, 8'd4, 32'h0BAD_0000));
        send(push_item(3'd1, 8'd4, 32'h0600_0D00));
        send(take_item(5'd16));

        random_phase(0, 0, 8'hFF, 1'b0);
        random_phase(88, 0, 8'($urandom), 1'b0);
        random_phase(0, 88, 8'($urandom) | 8'h81, 1'b1);
        random_phase(38, 38, 8'hFF, 1'b0);

        drain_results();
        repeat (END_SLACK) @(posedge clk);
        ring_log.flag_leftovers();
        if (ring_log.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
